[rtl/dmb_pkg.sv]
// ----------------------------------------------------------------------------
// dmb_pkg
// Types and fixed constants shared by the dot-matrix board I/O window.
// ----------------------------------------------------------------------------
package dmb_pkg;

    // op codes of an input request
    localparam logic [2:0] OP_BUS_READ  = 3'd0;
    localparam logic [2:0] OP_BUS_WRITE = 3'd1;
    localparam logic [2:0] OP_HOST_PUSH = 3'd2;
    localparam logic [2:0] OP_TICK      = 3'd3;
    localparam logic [2:0] OP_MAP_READ  = 3'd4;

    // bus addresses decoded by the window
    localparam logic [15:0] ADDR_STATUS   = 16'h2000;
    localparam logic [15:0] ADDR_MAP      = 16'h2800;
    localparam logic [15:0] ADDR_RING     = 16'h3000;
    localparam logic [15:0] ADDR_FIRQ_ACK = 16'h3800;

    // command kinds after classification
    localparam logic [2:0] CMD_NONE     = 3'd0;
    localparam logic [2:0] CMD_POP      = 3'd1;
    localparam logic [2:0] CMD_STATUS   = 3'd2;
    localparam logic [2:0] CMD_MAP_WR   = 3'd3;
    localparam logic [2:0] CMD_FIRQ_CLR = 3'd4;
    localparam logic [2:0] CMD_PUSH     = 3'd5;
    localparam logic [2:0] CMD_TICK     = 3'd6;
    localparam logic [2:0] CMD_MAP_RD   = 3'd7;

    localparam int RING_WRAP_LIMIT = 500;
    localparam logic [16:0] ACCUM_MAX = 17'h1FFFF;
    localparam logic [15:0] TICK_PERIOD_RESET = 16'd4000;

    localparam int CMD_QUEUE_DEPTH = 4;
    localparam int RES_QUEUE_DEPTH = 4;

    typedef struct packed {
        logic [2:0]  op;
        logic [15:0] addr;
        logic [7:0]  data;
        logic [7:0]  cycles;
        logic [7:0]  map_index;
    } item_t;

    typedef struct packed {
        logic [7:0] read_data;
        logic [7:0] map_byte;
        logic       irq_level;
        logic       firq_level;
        logic       frame_ready;
        logic [7:0] status_value;
    } result_t;

    // classified command: every kind needs at most one byte of argument
    typedef struct packed {
        logic [2:0] kind;
        logic [7:0] arg;
    } cmd_t;

    // what the writeback stage needs to finish a command
    typedef struct packed {
        logic       ring_ok;
        logic       map_rd_ok;
        logic       map_wr;
        logic       old_ok;
        logic       last;
        logic [7:0] wr_data;
        logic       irq;
        logic       firq;
        logic [7:0] status;
    } wb_t;

endpackage

[rtl/dmb_front.sv]
// ----------------------------------------------------------------------------
// dmb_front
// Accepts input requests and classifies them into one-byte commands.
// ----------------------------------------------------------------------------
module dmb_front
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push,
    output logic            full,
    input  dmb_pkg::item_t  item,
    input  logic            cq_ready,
    output logic            cq_wr,
    output dmb_pkg::cmd_t   cq_cmd
);

    logic          f_valid_reg;
    logic          f_valid_next;
    dmb_pkg::cmd_t f_cmd_reg;
    dmb_pkg::cmd_t dec_cmd;
    logic          accept;

    assign full   = f_valid_reg && !cq_ready;
    assign accept = push && !full;
    assign cq_wr  = f_valid_reg;
    assign cq_cmd = f_cmd_reg;

    always_comb
    begin
        dec_cmd.kind = dmb_pkg::CMD_NONE;
        dec_cmd.arg  = item.data;
        case (item.op)
            dmb_pkg::OP_BUS_READ:
            begin
                if (item.addr == dmb_pkg::ADDR_RING)
                begin
                    dec_cmd.kind = dmb_pkg::CMD_POP;
                end
            end
            dmb_pkg::OP_BUS_WRITE:
            begin
                if (item.addr == dmb_pkg::ADDR_STATUS)
                begin
                    dec_cmd.kind = dmb_pkg::CMD_STATUS;
                end
                else if (item.addr == dmb_pkg::ADDR_MAP)
                begin
                    dec_cmd.kind = dmb_pkg::CMD_MAP_WR;
                end
                else if (item.addr == dmb_pkg::ADDR_FIRQ_ACK)
                begin
                    dec_cmd.kind = dmb_pkg::CMD_FIRQ_CLR;
                end
            end
            dmb_pkg::OP_HOST_PUSH:
            begin
                dec_cmd.kind = dmb_pkg::CMD_PUSH;
            end
            dmb_pkg::OP_TICK:
            begin
                dec_cmd.kind = dmb_pkg::CMD_TICK;
                dec_cmd.arg  = item.cycles;
            end
            dmb_pkg::OP_MAP_READ:
            begin
                dec_cmd.kind = dmb_pkg::CMD_MAP_RD;
                dec_cmd.arg  = item.map_index;
            end
            default:
            begin
                dec_cmd.kind = dmb_pkg::CMD_NONE;
            end
        endcase
    end

    always_comb
    begin
        f_valid_next = f_valid_reg;
        if (accept)
        begin
            f_valid_next = 1'b1;
        end
        else if (f_valid_reg && cq_ready)
        begin
            f_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            f_valid_reg <= 1'b0;
        end
        else
        begin
            f_valid_reg <= f_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            f_cmd_reg <= dec_cmd;
        end
    end

endmodule

[rtl/dmb_cmd_queue.sv]
// ----------------------------------------------------------------------------
// dmb_cmd_queue
// Short command queue between the front end and the execution back end.
// ----------------------------------------------------------------------------
module dmb_cmd_queue
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          wr,
    input  dmb_pkg::cmd_t wr_cmd,
    output logic          ready,
    input  logic          rd,
    output logic          valid,
    output dmb_pkg::cmd_t rd_cmd
);

    localparam int DEPTH = dmb_pkg::CMD_QUEUE_DEPTH;
    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    dmb_pkg::cmd_t    mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic             do_wr;
    logic             do_rd;

    assign ready  = count_reg != CNT_W'(DEPTH);
    assign valid  = count_reg != '0;
    assign rd_cmd = mem_reg[rd_ptr_reg];
    assign do_wr  = wr && ready;
    assign do_rd  = rd && valid;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_wr)
        begin
            wr_ptr_next = wr_ptr_reg + PTR_W'(1);
        end
        if (do_rd)
        begin
            rd_ptr_next = rd_ptr_reg + PTR_W'(1);
        end
        if (do_wr && !do_rd)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        else if (do_rd && !do_wr)
        begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            mem_reg[wr_ptr_reg] <= wr_cmd;
        end
    end

endmodule

[rtl/dmb_back.sv]
// ----------------------------------------------------------------------------
// dmb_back
// Executes commands: ring and frame map memories, interrupt lines, tick
// accumulator, writeback stage and result queue.
// ----------------------------------------------------------------------------
module dmb_back
#(
    parameter int RING_DEPTH       = 512,
    parameter int BYTES_PER_BLOCK  = 9,
    parameter int BLOCKS_PER_FRAME = 21
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic [15:0]       tick_period,
    input  logic              cq_valid,
    input  dmb_pkg::cmd_t     cq_cmd,
    output logic              cq_rd,
    output logic              empty,
    input  logic              pop,
    output dmb_pkg::result_t  result
);

    localparam int RING_WRAP = (RING_DEPTH < dmb_pkg::RING_WRAP_LIMIT) ?
                               RING_DEPTH : dmb_pkg::RING_WRAP_LIMIT;
    localparam int RPTR_W    = $clog2(RING_WRAP);
    localparam int RFILL_W   = $clog2(RING_WRAP + 1);
    localparam int MAP_SIZE  = BYTES_PER_BLOCK * BLOCKS_PER_FRAME;
    localparam int MAP_AW    = (MAP_SIZE > 1) ? $clog2(MAP_SIZE) : 1;
    localparam int MFILL_W   = $clog2(MAP_SIZE + 1);
    localparam int IDX_W     = (MFILL_W > 8) ? MFILL_W : 8;
    localparam int BIB_W     = (BYTES_PER_BLOCK > 1) ? $clog2(BYTES_PER_BLOCK) : 1;
    localparam int BLK_W     = (BLOCKS_PER_FRAME > 1) ? $clog2(BLOCKS_PER_FRAME) : 1;
    localparam int RQ_DEPTH  = dmb_pkg::RES_QUEUE_DEPTH;
    localparam int RQ_PTR_W  = $clog2(RQ_DEPTH);
    localparam int RQ_CNT_W  = $clog2(RQ_DEPTH + 1);

    // memories
    logic [7:0]           ring_mem [RING_WRAP];
    logic [7:0]           map_mem  [MAP_SIZE];
    logic [7:0]           ring_q;
    logic [7:0]           map_q;

    // execute state
    logic [RPTR_W-1:0]    rd_ptr_reg,    rd_ptr_next;
    logic [RPTR_W-1:0]    wr_ptr_reg,    wr_ptr_next;
    logic [RFILL_W-1:0]   ring_fill_reg, ring_fill_next;
    logic [MAP_AW-1:0]    map_pos_reg,   map_pos_next;
    logic [MFILL_W-1:0]   map_fill_reg,  map_fill_next;
    logic [BIB_W-1:0]     bib_reg,       bib_next;
    logic [BLK_W-1:0]     blk_reg,       blk_next;
    logic                 irq_reg,       irq_next;
    logic                 firq_reg,      firq_next;
    logic [16:0]          accum_reg,     accum_next;
    logic [7:0]           status_reg,    status_next;

    // writeback state
    logic                 w_valid_reg;
    dmb_pkg::wb_t         w_reg;
    dmb_pkg::wb_t         w_next;
    logic                 changed_reg,   changed_next;

    // result queue
    dmb_pkg::result_t     rq_mem [RQ_DEPTH];
    logic [RQ_PTR_W-1:0]  rq_wr_ptr_reg;
    logic [RQ_PTR_W-1:0]  rq_rd_ptr_reg;
    logic [RQ_CNT_W-1:0]  rq_count_reg;
    logic [RQ_CNT_W-1:0]  rq_count_next;
    logic                 rq_pop;

    logic                 fire;
    logic [RQ_CNT_W:0]    in_flight;
    logic                 ring_we;
    logic                 map_we;
    logic [MAP_AW-1:0]    map_ra;
    logic [IDX_W-1:0]     idx_ext;
    logic                 idx_ok;
    logic [RPTR_W-1:0]    rd_ptr_inc;
    logic [17:0]          tick_sum;
    logic [16:0]          tick_sat;
    logic                 frame_last;
    logic [7:0]           old_byte;
    logic                 changed_now;
    dmb_pkg::result_t     wb_res;

    // reserve a result queue slot for every command in flight
    assign in_flight = (RQ_CNT_W + 1)'(rq_count_reg) + (RQ_CNT_W + 1)'(w_valid_reg);
    assign fire      = cq_valid && (in_flight < (RQ_CNT_W + 1)'(RQ_DEPTH));
    assign cq_rd     = fire;

    assign idx_ext    = IDX_W'(cq_cmd.arg);
    assign idx_ok     = (idx_ext < IDX_W'(MAP_SIZE)) && (idx_ext < IDX_W'(map_fill_reg));
    assign rd_ptr_inc = (rd_ptr_reg == RPTR_W'(RING_WRAP - 1)) ?
                        '0 : rd_ptr_reg + RPTR_W'(1);
    assign frame_last = (bib_reg == BIB_W'(BYTES_PER_BLOCK - 1)) &&
                        (blk_reg == BLK_W'(BLOCKS_PER_FRAME - 1));
    assign tick_sum   = {1'b0, accum_reg} + 18'(cq_cmd.arg);
    assign tick_sat   = (tick_sum > {1'b0, dmb_pkg::ACCUM_MAX}) ?
                        dmb_pkg::ACCUM_MAX : tick_sum[16:0];
    assign ring_we    = fire && (cq_cmd.kind == dmb_pkg::CMD_PUSH);
    assign map_we     = fire && (cq_cmd.kind == dmb_pkg::CMD_MAP_WR);
    assign map_ra     = (cq_cmd.kind == dmb_pkg::CMD_MAP_WR) ? map_pos_reg :
                        (idx_ok ? idx_ext[MAP_AW-1:0] : '0);

    always_comb
    begin
        rd_ptr_next    = rd_ptr_reg;
        wr_ptr_next    = wr_ptr_reg;
        ring_fill_next = ring_fill_reg;
        map_pos_next   = map_pos_reg;
        map_fill_next  = map_fill_reg;
        bib_next       = bib_reg;
        blk_next       = blk_reg;
        irq_next       = irq_reg;
        firq_next      = firq_reg;
        accum_next     = accum_reg;
        status_next    = status_reg;
        w_next.ring_ok   = 1'b0;
        w_next.map_rd_ok = 1'b0;
        w_next.map_wr    = 1'b0;
        w_next.old_ok    = 1'b0;
        w_next.last      = 1'b0;
        w_next.wr_data   = cq_cmd.arg;
        if (fire)
        begin
            case (cq_cmd.kind)
                dmb_pkg::CMD_POP:
                begin
                    // pointer moves even on an empty ring
                    w_next.ring_ok = RFILL_W'(rd_ptr_reg) < ring_fill_reg;
                    rd_ptr_next    = rd_ptr_inc;
                    if (rd_ptr_inc == wr_ptr_reg)
                    begin
                        irq_next = 1'b0;
                    end
                end
                dmb_pkg::CMD_STATUS:
                begin
                    status_next = cq_cmd.arg;
                end
                dmb_pkg::CMD_MAP_WR:
                begin
                    w_next.map_wr = 1'b1;
                    w_next.old_ok = MFILL_W'(map_pos_reg) < map_fill_reg;
                    w_next.last   = frame_last;
                    if (map_fill_reg != MFILL_W'(MAP_SIZE))
                    begin
                        map_fill_next = map_fill_reg + MFILL_W'(1);
                    end
                    if (bib_reg == BIB_W'(BYTES_PER_BLOCK - 1))
                    begin
                        bib_next = '0;
                        blk_next = (blk_reg == BLK_W'(BLOCKS_PER_FRAME - 1)) ?
                                   '0 : blk_reg + BLK_W'(1);
                    end
                    else
                    begin
                        bib_next = bib_reg + BIB_W'(1);
                    end
                    map_pos_next = frame_last ? '0 : map_pos_reg + MAP_AW'(1);
                end
                dmb_pkg::CMD_FIRQ_CLR:
                begin
                    firq_next = 1'b0;
                end
                dmb_pkg::CMD_PUSH:
                begin
                    // overwrites on overflow
                    wr_ptr_next = (wr_ptr_reg == RPTR_W'(RING_WRAP - 1)) ?
                                  '0 : wr_ptr_reg + RPTR_W'(1);
                    if (ring_fill_reg != RFILL_W'(RING_WRAP))
                    begin
                        ring_fill_next = ring_fill_reg + RFILL_W'(1);
                    end
                    irq_next = 1'b1;
                end
                dmb_pkg::CMD_TICK:
                begin
                    accum_next = tick_sat;
                    if (tick_sat >= {1'b0, tick_period})
                    begin
                        accum_next = tick_sat - {1'b0, tick_period};
                        firq_next  = 1'b1;
                    end
                end
                dmb_pkg::CMD_MAP_RD:
                begin
                    w_next.map_rd_ok = idx_ok;
                end
                default:
                begin
                    w_next.map_wr = 1'b0;
                end
            endcase
        end
        w_next.irq    = irq_next;
        w_next.firq   = firq_next;
        w_next.status = status_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_ptr_reg    <= '0;
            wr_ptr_reg    <= '0;
            ring_fill_reg <= '0;
            map_pos_reg   <= '0;
            map_fill_reg  <= '0;
            bib_reg       <= '0;
            blk_reg       <= '0;
            irq_reg       <= 1'b0;
            firq_reg      <= 1'b0;
            accum_reg     <= '0;
            status_reg    <= '0;
            w_valid_reg   <= 1'b0;
            changed_reg   <= 1'b0;
        end
        else
        begin
            rd_ptr_reg    <= rd_ptr_next;
            wr_ptr_reg    <= wr_ptr_next;
            ring_fill_reg <= ring_fill_next;
            map_pos_reg   <= map_pos_next;
            map_fill_reg  <= map_fill_next;
            bib_reg       <= bib_next;
            blk_reg       <= blk_next;
            irq_reg       <= irq_next;
            firq_reg      <= firq_next;
            accum_reg     <= accum_next;
            status_reg    <= status_next;
            w_valid_reg   <= fire;
            changed_reg   <= changed_next;
        end
    end

    // memories: read data registered, read returns the old byte on a same-cycle write
    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            w_reg  <= w_next;
            ring_q <= ring_mem[rd_ptr_reg];
            map_q  <= map_mem[map_ra];
        end
        if (ring_we)
        begin
            ring_mem[wr_ptr_reg] <= cq_cmd.arg;
        end
        if (map_we)
        begin
            map_mem[map_pos_reg] <= cq_cmd.arg;
        end
    end

    // writeback
    assign old_byte    = w_reg.old_ok ? map_q : 8'd0;
    assign changed_now = changed_reg || (w_reg.map_wr && (old_byte != w_reg.wr_data));

    always_comb
    begin
        changed_next = changed_reg;
        if (w_valid_reg && w_reg.map_wr)
        begin
            changed_next = w_reg.last ? 1'b0 : changed_now;
        end
        wb_res.read_data    = w_reg.ring_ok ? ring_q : 8'd0;
        wb_res.map_byte     = w_reg.map_rd_ok ? map_q : 8'd0;
        wb_res.irq_level    = w_reg.irq;
        wb_res.firq_level   = w_reg.firq;
        wb_res.frame_ready  = w_reg.map_wr && w_reg.last && changed_now;
        wb_res.status_value = w_reg.status;
    end

    // result queue
    assign empty  = rq_count_reg == '0;
    assign result = rq_mem[rq_rd_ptr_reg];
    assign rq_pop = pop && !empty;

    always_comb
    begin
        rq_count_next = rq_count_reg;
        if (w_valid_reg && !rq_pop)
        begin
            rq_count_next = rq_count_reg + RQ_CNT_W'(1);
        end
        else if (rq_pop && !w_valid_reg)
        begin
            rq_count_next = rq_count_reg - RQ_CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rq_wr_ptr_reg <= '0;
            rq_rd_ptr_reg <= '0;
            rq_count_reg  <= '0;
        end
        else
        begin
            if (w_valid_reg)
            begin
                rq_wr_ptr_reg <= rq_wr_ptr_reg + RQ_PTR_W'(1);
            end
            if (rq_pop)
            begin
                rq_rd_ptr_reg <= rq_rd_ptr_reg + RQ_PTR_W'(1);
            end
            rq_count_reg <= rq_count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (w_valid_reg)
        begin
            rq_mem[rq_wr_ptr_reg] <= wb_res;
        end
    end

endmodule

[rtl/dot_matrix_board_io.sv]
// ----------------------------------------------------------------------------
// dot_matrix_board_io
// I/O window of a dot-matrix display board: status latch, frame map,
// host character ring, IRQ/FIRQ lines and tick period register.
// ----------------------------------------------------------------------------
// Takes one request per clock unless full is high and returns one result per
// request, in order. A request passes a classify register, a 4-entry command
// queue, an execute stage that updates all state, reads the ring and frame
// map and writes at most one of them, and a writeback stage that reads the
// registered memory data; results wait in a 4-entry result queue. Sustained
// rate is one request per cycle while results are popped, set by the single
// execute stage. Memories need no clearing pass after reset: fill counts
// make unwritten ring and map entries read as zero. tick_period sits at APB
// byte address 0 and resets to 4000.
module dot_matrix_board_io
#(
    parameter int RING_DEPTH       = 512,
    parameter int BYTES_PER_BLOCK  = 9,
    parameter int BLOCKS_PER_FRAME = 21
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    output logic              full,
    input  dmb_pkg::item_t    item,
    output logic              empty,
    input  logic              pop,
    output dmb_pkg::result_t  result,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [2:0]        paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready
);

    logic          cq_wr;
    dmb_pkg::cmd_t cq_wr_cmd;
    logic          cq_ready;
    logic          cq_rd;
    logic          cq_valid;
    dmb_pkg::cmd_t cq_rd_cmd;
    logic [15:0]   tick_period_reg;
    logic          cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready && (paddr[2] == 1'b0);
    assign prdata = (paddr[2] == 1'b0) ? {16'd0, tick_period_reg} : 32'd0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tick_period_reg <= dmb_pkg::TICK_PERIOD_RESET;
        end
        else if (cfg_wr)
        begin
            tick_period_reg <= pwdata[15:0];
        end
    end

    dmb_front u_front
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .full     (full),
        .item     (item),
        .cq_ready (cq_ready),
        .cq_wr    (cq_wr),
        .cq_cmd   (cq_wr_cmd)
    );

    dmb_cmd_queue u_cmd_queue
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .wr     (cq_wr),
        .wr_cmd (cq_wr_cmd),
        .ready  (cq_ready),
        .rd     (cq_rd),
        .valid  (cq_valid),
        .rd_cmd (cq_rd_cmd)
    );

    dmb_back
    #(
        .RING_DEPTH       (RING_DEPTH),
        .BYTES_PER_BLOCK  (BYTES_PER_BLOCK),
        .BLOCKS_PER_FRAME (BLOCKS_PER_FRAME)
    )
    u_back
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .tick_period (tick_period_reg),
        .cq_valid    (cq_valid),
        .cq_cmd      (cq_rd_cmd),
        .cq_rd       (cq_rd),
        .empty       (empty),
        .pop         (pop),
        .result      (result)
    );

endmodule

[tb/board_io_checker.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// board_io_checker
// Watches the request, result and register channels of the board I/O window,
// predicts every result from its own copy of the board state and compares
// the results in order, field by field.
// ----------------------------------------------------------------------------
module board_io_checker
#(
    parameter int         RING_DEPTH       = 512,
    parameter int         BYTES_PER_BLOCK  = 9,
    parameter int         BLOCKS_PER_FRAME = 21,
    parameter logic [2:0] PERIOD_ADDR      = 3'd0
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  logic              full,
    input  dmb_pkg::item_t    item,
    input  logic              empty,
    input  logic              pop,
    input  dmb_pkg::result_t  result,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [2:0]        paddr,
    input  logic [31:0]       pwdata,
    input  logic [31:0]       prdata,
    input  logic              pready,
    output int                error_count,
    output int                pending_count
);

    localparam int RING_WRAP = (RING_DEPTH < dmb_pkg::RING_WRAP_LIMIT) ?
                               RING_DEPTH : dmb_pkg::RING_WRAP_LIMIT;
    localparam int MAP_SIZE  = BYTES_PER_BLOCK * BLOCKS_PER_FRAME;

    logic [15:0]      period_now;
    logic [7:0]       ring_mem [RING_DEPTH];
    logic [7:0]       frame_mem [MAP_SIZE];
    int               rd_ptr;
    int               wr_ptr;
    int               map_pos;
    int               byte_cnt;
    int               block_cnt;
    int               accum;
    bit               frame_dirty;
    bit               irq_line;
    bit               firq_line;
    logic [7:0]       status_byte;
    int               fails;
    dmb_pkg::result_t expected_results [$];

    task automatic clear_board();
        period_now = dmb_pkg::TICK_PERIOD_RESET;
        for (int i = 0; i < RING_DEPTH; i++)
        begin
            ring_mem[i] = '0;
        end
        for (int i = 0; i < MAP_SIZE; i++)
        begin
            frame_mem[i] = '0;
        end
        rd_ptr      = 0;
        wr_ptr      = 0;
        map_pos     = 0;
        byte_cnt    = 0;
        block_cnt   = 0;
        accum       = 0;
        frame_dirty = 0;
        irq_line    = 0;
        firq_line   = 0;
        status_byte = '0;
    endtask

    function automatic int ring_next(input int p);
        return (p + 1 >= RING_WRAP) ? 0 : p + 1;
    endfunction

    // returns 1 when this byte closes a frame that had a changed byte
    function automatic bit store_map_byte(input logic [7:0] v);
        bit done;
        done = 0;
        if (map_pos >= MAP_SIZE)
        begin
            map_pos = 0;
        end
        if (frame_mem[map_pos] != v)
        begin
            frame_dirty = 1;
        end
        frame_mem[map_pos] = v;
        map_pos++;
        byte_cnt++;
        if (byte_cnt >= BYTES_PER_BLOCK)
        begin
            byte_cnt = 0;
            block_cnt++;
            if (block_cnt >= BLOCKS_PER_FRAME)
            begin
                block_cnt   = 0;
                map_pos     = 0;
                done        = frame_dirty;
                frame_dirty = 0;
            end
        end
        return done;
    endfunction

    function automatic dmb_pkg::result_t predict_board_step(input dmb_pkg::item_t it);
        dmb_pkg::result_t r;
        bit               done;
        r    = '0;
        done = 0;
        case (it.op)
            dmb_pkg::OP_BUS_READ:
            begin
                if (it.addr == dmb_pkg::ADDR_RING)
                begin
                    if (rd_ptr >= RING_WRAP)
                    begin
                        rd_ptr = 0;
                    end
                    r.read_data = ring_mem[rd_ptr];
                    rd_ptr = ring_next(rd_ptr);
                    // the read that catches up with the writer drops irq
                    if (rd_ptr == wr_ptr)
                    begin
                        irq_line = 0;
                    end
                end
            end
            dmb_pkg::OP_BUS_WRITE:
            begin
                if (it.addr == dmb_pkg::ADDR_STATUS)
                begin
                    status_byte = it.data;
                end
                else if (it.addr == dmb_pkg::ADDR_MAP)
                begin
                    done = store_map_byte(it.data);
                end
                else if (it.addr == dmb_pkg::ADDR_FIRQ_ACK)
                begin
                    firq_line = 0;
                end
            end
            dmb_pkg::OP_HOST_PUSH:
            begin
                if (wr_ptr >= RING_WRAP)
                begin
                    wr_ptr = 0;
                end
                ring_mem[wr_ptr] = it.data;
                wr_ptr = ring_next(wr_ptr);
                irq_line = 1;
            end
            dmb_pkg::OP_TICK:
            begin
                accum += int'(it.cycles);
                if (accum > int'(dmb_pkg::ACCUM_MAX))
                begin
                    accum = int'(dmb_pkg::ACCUM_MAX);
                end
                // at most one period comes off per tick
                if (accum >= int'(period_now))
                begin
                    accum -= int'(period_now);
                    firq_line = 1;
                end
            end
            dmb_pkg::OP_MAP_READ:
            begin
                if (int'(it.map_index) < MAP_SIZE)
                begin
                    r.map_byte = frame_mem[it.map_index];
                end
            end
            default:
            begin
            end
        endcase
        r.irq_level    = irq_line;
        r.firq_level   = firq_line;
        r.frame_ready  = done;
        r.status_value = status_byte;
        return r;
    endfunction

    task automatic check_field(input string name, input logic [7:0] want, input logic [7:0] got);
        if (got !== want)
        begin
            $error("%s expected %0h actual %0h", name, want, got);
            fails++;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        dmb_pkg::result_t want;
        if (!rst_n)
        begin
            clear_board();
            expected_results.delete();
            fails = 0;
            error_count   <= 0;
            pending_count <= 0;
        end
        else
        begin
            if (psel && penable && pready && paddr == PERIOD_ADDR)
            begin
                if (pwrite)
                begin
                    period_now = pwdata[15:0];
                end
                else if (prdata !== {16'h0000, period_now})
                begin
                    $error("tick_period expected %0h actual %0h", period_now, prdata);
                    fails++;
                end
            end
            if (push && !full)
            begin
                expected_results.push_back(predict_board_step(item));
            end
            if (pop && !empty)
            begin
                if (expected_results.size() == 0)
                begin
                    $error("result with no request pending");
                    fails++;
                end
                else
                begin
                    want = expected_results.pop_front();
                    check_field("read_data", want.read_data, result.read_data);
                    check_field("map_byte", want.map_byte, result.map_byte);
                    check_field("irq_level", {7'b0, want.irq_level}, {7'b0, result.irq_level});
                    check_field("firq_level", {7'b0, want.firq_level},
                                {7'b0, result.firq_level});
                    check_field("frame_ready", {7'b0, want.frame_ready},
                                {7'b0, result.frame_ready});
                    check_field("status_value", want.status_value, result.status_value);
                end
            end
            error_count   <= fails;
            pending_count <= expected_results.size();
        end
    end

endmodule

[tb/tb_top.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Drives the board I/O window with directed and random bus, host and tick
// requests over several tick periods, with random idling on both sides,
// and reports the checker's verdict.
// ----------------------------------------------------------------------------
module tb_top;

    localparam int         RING_DEPTH       = 512;
    localparam int         BYTES_PER_BLOCK  = 9;
    localparam int         BLOCKS_PER_FRAME = 21;
    localparam int         MAP_SIZE         = BYTES_PER_BLOCK * BLOCKS_PER_FRAME;
    localparam logic [2:0] REG_TICK_PERIOD  = 3'd0;
    localparam int         PHASE_ITEMS      = 160;
    localparam int         STALL_LIMIT      = 2000;

    logic             clk;
    logic             rst_n;
    logic             push;
    logic             full;
    dmb_pkg::item_t   item;
    logic             empty;
    logic             pop;
    dmb_pkg::result_t result;
    logic             psel;
    logic             penable;
    logic             pwrite;
    logic [2:0]       paddr;
    logic [31:0]      pwdata;
    logic [31:0]      prdata;
    logic             pready;
    int               error_count;
    int               pending_count;

    int               sent_count;
    int               send_calm;
    int               pop_calm;
    int               map_wr_pos;
    logic [7:0]       frame_key;
    int               stall_cycles;

    dot_matrix_board_io
    #(
        .RING_DEPTH       (RING_DEPTH),
        .BYTES_PER_BLOCK  (BYTES_PER_BLOCK),
        .BLOCKS_PER_FRAME (BLOCKS_PER_FRAME)
    )
    u_top
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (push),
        .full    (full),
        .item    (item),
        .empty   (empty),
        .pop     (pop),
        .result  (result),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    board_io_checker
    #(
        .RING_DEPTH       (RING_DEPTH),
        .BYTES_PER_BLOCK  (BYTES_PER_BLOCK),
        .BLOCKS_PER_FRAME (BLOCKS_PER_FRAME),
        .PERIOD_ADDR      (REG_TICK_PERIOD)
    )
    u_checker
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .push          (push),
        .full          (full),
        .item          (item),
        .empty         (empty),
        .pop           (pop),
        .result        (result),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .error_count   (error_count),
        .pending_count (pending_count)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #10 clk = ~clk;

    function automatic logic [7:0] rand_byte();
        return 8'($urandom);
    endfunction

    function automatic logic [15:0] rand_word();
        return 16'($urandom);
    endfunction

    function automatic dmb_pkg::item_t make_req(input logic [2:0] op, input logic [15:0] a,
                                                input logic [7:0] d, input logic [7:0] c,
                                                input logic [7:0] m);
        dmb_pkg::item_t it;
        it.op        = op;
        it.addr      = a;
        it.data      = d;
        it.cycles    = c;
        it.map_index = m;
        return it;
    endfunction

    // wait before the next request, with calm stretches of back-to-back traffic
    task automatic draw_wait(inout int calm, output int n);
        if (calm > 0)
        begin
            calm--;
            n = 0;
        end
        else
        begin
            if ($urandom_range(0, 29) == 0)
            begin
                calm = $urandom_range(10, 40);
            end
            n = $urandom_range(0, 12);
        end
    endtask

    task automatic send_req(input dmb_pkg::item_t it);
        int gap;
        draw_wait(send_calm, gap);
        if (gap > 0)
        begin
            push <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        push <= 1'b1;
        item <= it;
        @(posedge clk);
        while (full) @(posedge clk);
        sent_count++;
    endtask

    task automatic apb_access(input logic wr, input logic [2:0] a, input logic [31:0] d);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= a;
        pwdata  <= d;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready) @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
    endtask

    // let every request in flight come back before touching the register
    task automatic drain();
        push <= 1'b0;
        @(posedge clk);
        while (pending_count != 0) @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    // stream frame bytes with a pattern that often repeats the previous frame
    task automatic map_burst();
        int n;
        n = $urandom_range(20, 80);
        if ($urandom_range(0, 3) == 0)
        begin
            frame_key = rand_byte();
        end
        repeat (n)
        begin
            if ($urandom_range(0, 6) != 0)
            begin
                send_req(make_req(dmb_pkg::OP_BUS_WRITE, dmb_pkg::ADDR_MAP,
                                  frame_key ^ 8'(map_wr_pos), rand_byte(), rand_byte()));
                map_wr_pos = (map_wr_pos + 1) % MAP_SIZE;
            end
            else
            begin
                send_req(make_req(dmb_pkg::OP_MAP_READ, rand_word(), rand_byte(), rand_byte(),
                                  8'($urandom_range(0, MAP_SIZE - 1))));
            end
        end
    endtask

    task automatic ring_burst(input int n, input int bias);
        repeat (n)
        begin
            if ($urandom_range(0, 3) < bias)
            begin
                send_req(make_req(dmb_pkg::OP_HOST_PUSH, rand_word(), rand_byte(),
                                  rand_byte(), rand_byte()));
            end
            else
            begin
                send_req(make_req(dmb_pkg::OP_BUS_READ, dmb_pkg::ADDR_RING, rand_byte(),
                                  rand_byte(), rand_byte()));
            end
        end
    endtask

    task automatic tick_burst();
        int n;
        int r;
        logic [7:0] c;
        n = $urandom_range(5, 40);
        repeat (n)
        begin
            r = $urandom_range(0, 9);
            if (r == 0)
            begin
                send_req(make_req(dmb_pkg::OP_BUS_WRITE, dmb_pkg::ADDR_FIRQ_ACK, rand_byte(),
                                  rand_byte(), rand_byte()));
            end
            else
            begin
                c = (r == 1) ? 8'hFF : (r == 2) ? 8'h00 : rand_byte();
                send_req(make_req(dmb_pkg::OP_TICK, rand_word(), rand_byte(), c,
                                  rand_byte()));
            end
        end
    endtask

    task automatic map_read_burst();
        int n;
        logic [7:0] m;
        n = $urandom_range(4, 16);
        repeat (n)
        begin
            m = ($urandom_range(0, 3) == 0) ? rand_byte() : 8'($urandom_range(0, MAP_SIZE - 1));
            send_req(make_req(dmb_pkg::OP_MAP_READ, rand_word(), rand_byte(), rand_byte(), m));
        end
    endtask

    // bus traffic to decoded and stray addresses, plus fully random requests
    task automatic misc_burst(input bit wild);
        int n;
        logic [15:0] a;
        logic [2:0] op;
        n = $urandom_range(4, 16);
        repeat (n)
        begin
            case ($urandom_range(0, 4))
                0: a = dmb_pkg::ADDR_STATUS;
                1: a = dmb_pkg::ADDR_MAP;
                2: a = dmb_pkg::ADDR_RING;
                3: a = dmb_pkg::ADDR_FIRQ_ACK;
                default: a = rand_word();
            endcase
            if (wild)
            begin
                op = 3'($urandom_range(0, 4));
                a  = rand_word();
            end
            else
            begin
                op = $urandom_range(0, 1) ? dmb_pkg::OP_BUS_WRITE : dmb_pkg::OP_BUS_READ;
            end
            send_req(make_req(op, a, rand_byte(), rand_byte(), rand_byte()));
        end
    endtask

    task automatic random_phase(input int count);
        int phase_end;
        phase_end = sent_count + count;
        while (sent_count < phase_end)
        begin
            case ($urandom_range(0, 9))
                0, 1, 2: map_burst();
                3, 4, 5: ring_burst($urandom_range(4, 40), $urandom_range(1, 3));
                6: tick_burst();
                7: map_read_burst();
                8: misc_burst(1'b0);
                default: misc_burst(1'b1);
            endcase
        end
    endtask

    initial
    begin
        logic [15:0] periods [5];
        sent_count = 0;
        send_calm  = 0;
        map_wr_pos = 0;
        frame_key  = '0;
        periods[0] = dmb_pkg::TICK_PERIOD_RESET;
        periods[1] = 16'd1;
        periods[2] = 16'hFFFF;
        periods[3] = 16'($urandom_range(2, 65534));
        periods[4] = 16'($urandom_range(20, 300));
        rst_n   <= 1'b0;
        push    <= 1'b0;
        item    <= '0;
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= '0;
        pwdata  <= '0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        apb_access(1'b0, REG_TICK_PERIOD, '0);

        // empty ring read, push then read past the writer
        send_req(make_req(dmb_pkg::OP_BUS_READ, dmb_pkg::ADDR_RING, rand_byte(), rand_byte(),
                          rand_byte()));
        send_req(make_req(dmb_pkg::OP_HOST_PUSH, rand_word(), 8'h00, rand_byte(),
                          rand_byte()));
        send_req(make_req(dmb_pkg::OP_HOST_PUSH, rand_word(), 8'hFF, rand_byte(),
                          rand_byte()));
        send_req(make_req(dmb_pkg::OP_BUS_READ, dmb_pkg::ADDR_RING, rand_byte(), rand_byte(),
                          rand_byte()));
        send_req(make_req(dmb_pkg::OP_BUS_READ, dmb_pkg::ADDR_RING, rand_byte(), rand_byte(),
                          rand_byte()));
        send_req(make_req(dmb_pkg::OP_BUS_WRITE, dmb_pkg::ADDR_STATUS, 8'hFF, rand_byte(),
                          rand_byte()));
        send_req(make_req(dmb_pkg::OP_BUS_WRITE, dmb_pkg::ADDR_STATUS, 8'h00, rand_byte(),
                          rand_byte()));
        send_req(make_req(dmb_pkg::OP_BUS_WRITE, dmb_pkg::ADDR_MAP, 8'hFF, rand_byte(),
                          rand_byte()));
        send_req(make_req(dmb_pkg::OP_BUS_WRITE, dmb_pkg::ADDR_MAP, 8'h00, rand_byte(),
                          rand_byte()));
        map_wr_pos = 2;
        send_req(make_req(dmb_pkg::OP_MAP_READ, rand_word(), rand_byte(), rand_byte(), 8'd0));
        send_req(make_req(dmb_pkg::OP_MAP_READ, rand_word(), rand_byte(), rand_byte(),
                          8'd188));
        send_req(make_req(dmb_pkg::OP_MAP_READ, rand_word(), rand_byte(), rand_byte(),
                          8'd189));
        send_req(make_req(dmb_pkg::OP_MAP_READ, rand_word(), rand_byte(), rand_byte(),
                          8'hFF));
        send_req(make_req(dmb_pkg::OP_TICK, rand_word(), rand_byte(), 8'hFF, rand_byte()));
        send_req(make_req(dmb_pkg::OP_TICK, rand_word(), rand_byte(), 8'h00, rand_byte()));
        send_req(make_req(dmb_pkg::OP_BUS_WRITE, dmb_pkg::ADDR_FIRQ_ACK, rand_byte(),
                          rand_byte(), rand_byte()));
        send_req(make_req(dmb_pkg::OP_BUS_READ, 16'hFFFF, rand_byte(), rand_byte(),
                          rand_byte()));
        send_req(make_req(dmb_pkg::OP_BUS_READ, 16'h0000, rand_byte(), rand_byte(),
                          rand_byte()));
        send_req(make_req(dmb_pkg::OP_BUS_READ, dmb_pkg::ADDR_STATUS, rand_byte(),
                          rand_byte(), rand_byte()));
        send_req(make_req(dmb_pkg::OP_BUS_WRITE, 16'h0000, 8'hAA, rand_byte(), rand_byte()));
        send_req(make_req(dmb_pkg::OP_BUS_WRITE, 16'hFFFF, 8'h55, rand_byte(), rand_byte()));

        for (int p = 0; p < 5; p++)
        begin
            if (p > 0)
            begin
                drain();
                apb_access(1'b1, REG_TICK_PERIOD, {16'h0000, periods[p]});
                apb_access(1'b0, REG_TICK_PERIOD, '0);
            end
            // overrun the ring once: the writer laps the reader
            if (p == 2)
            begin
                ring_burst(510, 4);
                ring_burst(30, 0);
            end
            random_phase(PHASE_ITEMS);
        end

        push <= 1'b0;
        @(posedge clk);
        while (pending_count != 0) @(posedge clk);
        repeat (10) @(posedge clk);
        if (error_count == 0)
        begin
            $display("DONE: 0 errors");
        end
        else
        begin
            $display("DONE: errors detected");
        end
        $finish;
    end

    initial
    begin
        int stall;
        pop_calm = 0;
        pop <= 1'b0;
        @(posedge clk);
        forever
        begin
            draw_wait(pop_calm, stall);
            if (stall > 0)
            begin
                pop <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            pop <= 1'b1;
            @(posedge clk);
            while (empty) @(posedge clk);
        end
    end

    // ends the run when no request, result or register access moves for too long
    always @(posedge clk)
    begin
        if (!rst_n || (push && !full) || (pop && !empty) || (psel && penable && pready))
        begin
            stall_cycles <= 0;
        end
        else
        begin
            stall_cycles <= stall_cycles + 1;
            if (stall_cycles >= STALL_LIMIT)
            begin
                $display("DONE: errors detected");
                $finish;
            end
        end
    end

endmodule

[sim.f]
rtl/dmb_pkg.sv
rtl/dmb_front.sv
rtl/dmb_cmd_queue.sv
rtl/dmb_back.sv
rtl/dot_matrix_board_io.sv
tb/board_io_checker.sv
tb/tb_top.sv
